FILE: src/fcrs_pkg.sv
// Shared types, constants and helper functions of the focus contrast-ratio statistics block.
`timescale 1ns / 1ps

package fcrs_pkg;

  localparam int PIX_W     = 32;
  localparam int ACC_W     = 40;
  localparam int DIM_W     = 14;
  localparam int CNT_W     = 13;
  localparam int BYTE_W    = 8;
  localparam int SUM_W     = 10;
  localparam int MUL_W     = DIM_W + 2;
  localparam int HIST_D    = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] DIM_MIN      = 14'd16;
  localparam logic [DIM_W-1:0] DIM_MAX      = 14'd8192;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 14'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 14'd480;

  localparam logic [ACC_W-1:0] ACC_MAX     = {ACC_W{1'b1}};
  localparam logic [PIX_W-1:0] CENTER_MASK = 32'hFFFF_FF00;
  localparam logic [CNT_W-1:0] HALF_SPAN   = 13'd4;

  // ceil(2^19 / 9); exact floor(v / 9) for every v below 74898.
  localparam logic [31:0] RECIP_9   = 32'd58255;
  localparam int          RECIP_SHR = 19;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_ACC,
    ST_EMIT
  } fcrs_state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic div_step;
    logic acc_add;
    logic out_load;
  } fcrs_cmd_t;

  typedef struct packed {
    logic ratio_needed;
    logic div_last;
    logic out_free;
  } fcrs_status_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_MIN) begin
      r = DIM_MIN;
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] div9(input logic [MUL_W-1:0] v);
    logic [31:0] prod;
    prod = {16'd0, v} * RECIP_9;
    return prod[RECIP_SHR +: CNT_W];
  endfunction

endpackage

FILE: src/focus_contrast_ratio_stats.sv
// Top level of the focus contrast-ratio statistics block: controller plus datapath.
// A request passes through capture, evaluation, then, when a ratio is formed, the serial
// division and accumulation, and last the load of the output register; the next request
// is accepted only after that load. The serial divider produces one quotient bit per
// cycle. Reset clears counters, history, accumulator, the output register's valid bit
// and restores frame size 640 x 480.
`timescale 1ns / 1ps

module focus_contrast_ratio_stats #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fcrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fcrs_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fcrs_pkg::PIX_W-1:0]     pixel_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fcrs_pkg::PIX_W-1:0]     pixel_out,
  output logic [fcrs_pkg::ACC_W-1:0]     focus_sum,
  output logic                           sum_valid
);
  import fcrs_pkg::*;

  // The controller walks each request through capture, evaluation, an optional
  // serial division with accumulation and the load of the output register. Because
  // the result sits in its own register, the next request is accepted while the
  // previous result still waits to be taken downstream.
  fcrs_cmd_t    cmd;
  fcrs_status_t status;

  fcrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath tracks the pixel position itself, keeps the last seven low
  // bytes for the left and right sums, divides the larger sum by the smaller
  // one and adds the quotient to a saturating 40-bit accumulator, which is
  // reported and cleared on the last pixel of each frame.
  fcrs_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_word (pixel_word),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .pixel_out  (pixel_out),
    .focus_sum  (focus_sum),
    .sum_valid  (sum_valid)
  );

endmodule

FILE: src/fcrs_ctrl.sv
// Controller state machine sequencing one pixel request through the datapath.
`timescale 1ns / 1ps

module fcrs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fcrs_pkg::fcrs_status_t status,
  output fcrs_pkg::fcrs_cmd_t    cmd
);
  import fcrs_pkg::*;

  fcrs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = status.ratio_needed ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc_add = 1'b1;
        state_next  = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/fcrs_datapath.sv
// Datapath: counters, low-byte history, window bounds, serial divider, accumulator, output register.
`timescale 1ns / 1ps

module fcrs_datapath #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fcrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcrs_pkg::DIM_W-1:0]       cfg_data,
  input  logic [fcrs_pkg::PIX_W-1:0]       pixel_word,
  input  fcrs_pkg::fcrs_cmd_t              cmd,
  output fcrs_pkg::fcrs_status_t           status,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [fcrs_pkg::PIX_W-1:0]       pixel_out,
  output logic [fcrs_pkg::ACC_W-1:0]       focus_sum,
  output logic                             sum_valid
);
  import fcrs_pkg::*;

  localparam int QW     = SUM_W + FRACTION_BITS;
  localparam int QCNT_W = $clog2(QW);

  logic [DIM_W-1:0]  frame_width, frame_height;
  logic [DIM_W-1:0]  wc, hc;
  logic [CNT_W-1:0]  col_lo, col_hi, row_lo, row_hi, width_m1, height_m1;
  logic [CNT_W-1:0]  column_count, row_count;
  logic [BYTE_W-1:0] history [HIST_D];
  logic [PIX_W-1:0]  pix;
  logic [ACC_W-1:0]  acc;
  logic              win_flag, last_flag;
  logic [SUM_W-1:0]  rem, divisor;
  logic [QW-1:0]     dvd;
  logic [QCNT_W-1:0] qcnt;

  logic [BYTE_W-1:0] cur;
  logic [SUM_W-1:0]  left_sum, right_sum, big, small_sum;
  logic [CNT_W-1:0]  xm4;
  logic              row_in, col_in, ratio_col, last_col, last;
  logic [SUM_W:0]    rem_sh;
  logic              ge;
  logic [ACC_W:0]    acc_sum;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FRAME_WIDTH) begin
        frame_width <= cfg_data;
      end else if (cfg_index == CFG_FRAME_HEIGHT) begin
        frame_height <= cfg_data;
      end
    end
  end

  // Window bounds are registered from the clamped configuration and follow it in the next cycle.
  assign wc = clamp_dim(frame_width);
  assign hc = clamp_dim(frame_height);

  always_ff @(posedge clk) begin
    width_m1  <= CNT_W'(wc - DIM_W'(1));
    height_m1 <= CNT_W'(hc - DIM_W'(1));
    col_lo    <= div9({wc, 2'b00});
    col_hi    <= div9({wc, 2'b00} + {2'b00, wc});
    row_lo    <= div9({hc, 2'b00});
    row_hi    <= div9({hc, 2'b00} + {2'b00, hc});
  end

  // Position and window decisions for the captured pixel.
  assign cur       = pix[BYTE_W-1:0];
  assign row_in    = (row_count >= row_lo) && (row_count < row_hi);
  assign col_in    = (column_count >= col_lo) && (column_count < col_hi);
  assign xm4       = column_count - HALF_SPAN;
  assign ratio_col = (column_count >= HALF_SPAN) && (xm4 >= col_lo) && (xm4 < col_hi);
  assign last_col  = column_count >= width_m1;
  assign last      = last_col && (row_count >= height_m1);

  assign left_sum  = SUM_W'(history[3]) + SUM_W'(history[4])
                   + SUM_W'(history[5]) + SUM_W'(history[6]);
  assign right_sum = SUM_W'(history[0]) + SUM_W'(history[1])
                   + SUM_W'(history[2]) + SUM_W'(cur);
  assign big       = (left_sum > right_sum) ? left_sum : right_sum;
  assign small_sum = (left_sum > right_sum) ? right_sum : left_sum;

  // Restoring divider step.
  assign rem_sh = {rem, dvd[QW-1]};
  assign ge     = rem_sh >= {1'b0, divisor};

  assign acc_sum = {1'b0, acc} + (ACC_W + 1)'(dvd);

  assign status.ratio_needed = row_in && ratio_col && (small_sum != '0);
  assign status.div_last     = qcnt == QCNT_W'(QW - 1);
  assign status.out_free     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix <= pixel_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      win_flag  <= row_in && col_in;
      last_flag <= last;
      rem       <= '0;
      divisor   <= small_sum;
      dvd       <= QW'(big) << FRACTION_BITS;
      qcnt      <= '0;
    end else if (cmd.div_step) begin
      rem  <= ge ? SUM_W'(rem_sh - {1'b0, divisor}) : SUM_W'(rem_sh);
      dvd  <= {dvd[QW-2:0], ge};
      qcnt <= qcnt + QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      for (int i = 0; i < HIST_D; i++) begin
        history[i] <= '0;
      end
    end else if (cmd.eval) begin
      history[0] <= cur;
      for (int i = 1; i < HIST_D; i++) begin
        history[i] <= history[i-1];
      end
      if (last) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (last_col) begin
        column_count <= '0;
        row_count    <= row_count + CNT_W'(1);
      end else begin
        column_count <= column_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
    end else if (cmd.out_load && last_flag) begin
      acc <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixel_out <= win_flag ? (pix & CENTER_MASK) : pix;
      focus_sum <= last_flag ? acc : '0;
      sum_valid <= last_flag;
    end
  end

endmodule

FILE: test/fcrs_checker.sv
// Result predictor and comparator for the focus contrast-ratio statistics block.
`timescale 1ns / 1ps

module fcrs_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fcrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fcrs_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [fcrs_pkg::PIX_W-1:0]     pixel_word,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [fcrs_pkg::PIX_W-1:0]     pixel_out,
  input  logic [fcrs_pkg::ACC_W-1:0]     focus_sum,
  input  logic                           sum_valid,
  output int                             fail_count,
  output int                             pending,
  output int                             frames_done,
  output int                             ratios_added
);
  import fcrs_pkg::*;

  localparam int FRAC = 8;
  localparam int REPORT_CAP = 40;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [ACC_W-1:0] sum;
    logic             last;
  } pixel_result_t;

  pixel_result_t     result_q[$];
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  logic [BYTE_W-1:0] low_hist [HIST_D];
  logic [CNT_W-1:0]  col;
  logic [CNT_W-1:0]  row;
  logic [ACC_W-1:0]  ratio_acc;

  function automatic int unsigned bound_dim(input logic [DIM_W-1:0] v);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  task automatic report(input string what, input logic [ACC_W-1:0] want, got);
    fail_count++;
    if (fail_count <= REPORT_CAP) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // Works out the result of one accepted pixel and advances the position,
  // history and accumulator.
  task automatic predict_pixel(input logic [PIX_W-1:0] pix);
    int unsigned w, h, c0, c1, r0, r1, x, y, left, right, big, least, i;
    logic [BYTE_W-1:0] cur;
    logic row_in, last_col, last;
    logic [63:0] ratio;
    pixel_result_t r;
    w = bound_dim(width_reg);
    h = bound_dim(height_reg);
    c0 = w * 4 / 9;
    c1 = w * 5 / 9;
    r0 = h * 4 / 9;
    r1 = h * 5 / 9;
    cur = pix[7:0];
    x = col;
    y = row;
    row_in = (y >= r0) && (y < r1);
    last_col = (x >= w - 1);
    last = last_col && (y >= h - 1);

    // The ratio for center column x-4 is formed once its right-hand pixels are in.
    if (row_in && x >= 4 && (x - 4) >= c0 && (x - 4) < c1) begin
      left = low_hist[3] + low_hist[4] + low_hist[5] + low_hist[6];
      right = low_hist[0] + low_hist[1] + low_hist[2] + cur;
      big = (left > right) ? left : right;
      least = (left > right) ? right : left;
      if (least != 0) begin
        ratio = ({32'd0, big} << FRAC) / least;
        if (ratio > {24'd0, ACC_MAX} - {24'd0, ratio_acc}) begin
          ratio_acc = ACC_MAX;
        end else begin
          ratio_acc = ratio_acc + ratio[ACC_W-1:0];
        end
        ratios_added++;
      end
    end

    r.pixel = (row_in && x >= c0 && x < c1) ? {pix[PIX_W-1:8], 8'h00} : pix;
    r.sum = last ? ratio_acc : '0;
    r.last = last;
    result_q.push_back(r);

    for (i = HIST_D - 1; i > 0; i--) begin
      low_hist[i] = low_hist[i-1];
    end
    low_hist[0] = cur;

    if (last) begin
      ratio_acc = '0;
      col = '0;
      row = '0;
      frames_done++;
    end else if (last_col) begin
      col = '0;
      row = CNT_W'(y + 1);
    end else begin
      col = CNT_W'(x + 1);
    end
  endtask

  always @(posedge clk) begin
    pixel_result_t want;
    if (rst) begin
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      for (int k = 0; k < HIST_D; k++) begin
        low_hist[k] = '0;
      end
      col = '0;
      row = '0;
      ratio_acc = '0;
      result_q.delete();
      fail_count = 0;
      frames_done = 0;
      ratios_added = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FRAME_WIDTH) begin
          width_reg = cfg_data;
        end else if (cfg_index == CFG_FRAME_HEIGHT) begin
          height_reg = cfg_data;
        end
      end
      if (in_valid && in_ready) begin
        predict_pixel(pixel_word);
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_CAP) begin
            $display("%0t ns: result with nothing expected, expected none, actual %h",
                     $time, pixel_out);
          end
        end else begin
          want = result_q.pop_front();
          if (pixel_out !== want.pixel) report("pixel_out", want.pixel, pixel_out);
          if (focus_sum !== want.sum) report("focus_sum", want.sum, focus_sum);
          if (sum_valid !== want.last) report("sum_valid", want.last, sum_valid);
        end
      end
    end
    pending = result_q.size();
  end

endmodule

FILE: test/tb_focus_contrast_ratio_stats.sv
// Testbench top for the focus contrast-ratio statistics block: stimulus and verdict.
`timescale 1ns / 1ps

module tb_focus_contrast_ratio_stats;
  import fcrs_pkg::*;

  // Total pixel requests, and the point from which neither side idles any more.
  localparam int TOTAL_PIXELS = 1950;
  localparam int QUIET_FROM = TOTAL_PIXELS - 250;
  // Length of the single long output stall that backs the block up.
  localparam int LONG_HOLD_CYCLES = 300;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int SETTLE_CYCLES = 30;

  typedef enum int {LOW_NOISE, LOW_FLAT, LOW_SPARSE, LOW_EXTREME} low_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     pixel_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     pixel_out;
  logic [ACC_W-1:0]     focus_sum;
  logic                 sum_valid;

  int fail_count;
  int pending;
  int frames_done;
  int ratios_added;

  // Pacing controls shared between the request driver and the output side.
  int   sent_count = 0;
  bit   tx_idle_on = 1'b0;
  bit   rx_idle_on = 1'b0;
  logic long_hold = 1'b0;
  bit   hold_taken = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  focus_contrast_ratio_stats dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_word (pixel_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .focus_sum  (focus_sum),
    .sum_valid  (sum_valid)
  );

  fcrs_checker ratio_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_word   (pixel_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_out    (pixel_out),
    .focus_sum    (focus_sum),
    .sum_valid    (sum_valid),
    .fail_count   (fail_count),
    .pending      (pending),
    .frames_done  (frames_done),
    .ratios_added (ratios_added)
  );

  // A hung handshake or a lost result ends the run here.
  initial begin
    #5_000_000;
    $display("[focus_contrast_ratio_stats] ERROR");
    $finish;
  end

  // Output side. Ready drops in random bursts while idling is allowed, and
  // once, on request, for one long stretch so that the block fills up and
  // has to refuse new requests. Each step makes exactly one assignment to
  // out_ready, so there is no ordering hazard inside a time step.
  initial begin
    int rx_hold;
    rx_hold = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (long_hold && !hold_taken) begin
        hold_taken = 1'b1;
        rx_hold = LONG_HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (rx_idle_on && sent_count < QUIET_FROM && $urandom_range(0, 7) == 0) begin
        rx_hold = $urandom_range(1, 11) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Builds one pixel. The upper 24 bits are mostly random with the all-ones
  // and all-zeros patterns mixed in; the low byte, which feeds the sums,
  // follows the chosen mode.
  function automatic logic [PIX_W-1:0] make_pixel(input low_mode_t mode,
                                                  input logic [7:0] level);
    logic [23:0] upper;
    logic [7:0]  low;
    case ($urandom_range(0, 9))
      0: begin
        upper = '1;
      end
      1: begin
        upper = '0;
      end
      default: begin
        upper = 24'($urandom);
      end
    endcase
    case (mode)
      LOW_FLAT: begin
        // Equal left and right sums, so the ratio is exactly one.
        low = level;
      end
      LOW_SPARSE: begin
        // Mostly dark, so the smaller sum is often zero.
        low = ($urandom_range(0, 3) != 0) ? 8'd0 : 8'($urandom);
      end
      LOW_EXTREME: begin
        case ($urandom_range(0, 2))
          0: begin
            low = 8'd0;
          end
          1: begin
            low = 8'd1;
          end
          default: begin
            low = 8'hFF;
          end
        endcase
      end
      default: begin
        low = 8'($urandom);
      end
    endcase
    return {upper, low};
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offers one request and returns at the falling edge after it was taken.
  // Valid goes low only for an idle burst, never between back-to-back requests.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    if (tx_idle_on && sent_count < QUIET_FROM && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    pixel_word <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  // Sends a run of pixels whose low-byte pattern changes now and then.
  task automatic send_run(input int count);
    low_mode_t mode;
    logic [7:0] level;
    mode = low_mode_t'($urandom_range(0, 3));
    level = pick_level();
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) begin
        mode = low_mode_t'($urandom_range(0, 3));
        level = pick_level();
      end
      send_pixel(make_pixel(mode, level));
    end
  endtask

  // Stops offering and waits until every predicted result has come back.
  // Every request yields a result, so the block is idle after that.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic program_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [PIX_W-1:0] corner_pixels [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_00FF,
                                            32'hFFFF_FF00, 32'h8000_0001, 32'h7FFF_FFFE,
                                            32'h0000_0001, 32'hA5A5_5A5A};
    logic [DIM_W-1:0] odd_dims [7] = '{14'd0, 14'd15, 14'd16, 14'd8191, 14'd8192,
                                       14'd8193, 14'h3FFF};
    int unsigned roll;
    int unsigned w;
    int unsigned h;
    int n;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening. First the extreme pixel values at the reset frame size.
    foreach (corner_pixels[i]) begin
      send_pixel(corner_pixels[i]);
    end
    wait_drained();

    // Out-of-range sizes on both registers: the widest setting clamps to 8192
    // and a zero height clamps to 16, mid-frame.
    program_frame(14'h3FFF, 14'd0);
    send_run(10);
    wait_drained();

    // Shrink the width while the column count is already past the new last
    // column: the next request has to close the row. Height goes to its maximum.
    program_frame(14'd0, 14'd8192);
    send_run(5);

    // Random part. Each round programs a small frame, streams a good share of
    // it with mixed low-byte patterns, and sometimes makes a short excursion
    // to an extreme or out-of-range size before shrinking back, so that the
    // counters end up beyond the new size.
    while (sent_count < TOTAL_PIXELS) begin
      wait_drained();
      roll = $urandom_range(0, 19);
      if (roll < 14) begin
        w = $urandom_range(16, 24);
      end else if (roll < 19) begin
        w = $urandom_range(25, 48);
      end else begin
        w = $urandom_range(49, 96);
      end
      h = ($urandom_range(0, 4) != 0) ? $urandom_range(16, 18) : $urandom_range(19, 32);
      program_frame(DIM_W'(w), DIM_W'(h));

      // Some rounds idle on one side only, some on both, some on neither.
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);

      n = $urandom_range(w * h / 3, w * h);
      if (n > TOTAL_PIXELS - sent_count) begin
        n = TOTAL_PIXELS - sent_count;
      end
      // One long output stall while requests keep coming.
      if (!long_hold && sent_count > 100 && n >= 100) begin
        long_hold <= 1'b1;
      end
      send_run(n);

      if (sent_count < QUIET_FROM && $urandom_range(0, 3) == 0) begin
        wait_drained();
        write_reg($urandom_range(0, 1) ? CFG_FRAME_HEIGHT : CFG_FRAME_WIDTH,
                  odd_dims[$urandom_range(0, 6)]);
        send_run($urandom_range(1, 24));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d pixel requests over %0d completed frames,", sent_count,
             frames_done);
    $display("with %0d contrast ratios accumulated inside the center window.", ratios_added);
    if (fail_count == 0) begin
      $display("[focus_contrast_ratio_stats] OK");
    end else begin
      $display("[focus_contrast_ratio_stats] ERROR");
    end
    $finish;
  end

endmodule
